>>> sv/act_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_pkg
// Types, codes and defaults used by the collider table.
// ----------------------------------------------------------------------------
package act_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KINDS_DEF = 16;

  // a scan delivers at most this many notices before its done marker
  localparam int MAX_NOTES  = 30;
  localparam int NOTE_CNT_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MASK_REGS  = 4;
  localparam int INIT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_0_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_4_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_8_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_12_15 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIATOR  = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MARK  = 3'd1,
    OP_PURGE = 3'd2,
    OP_SCAN  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    RK_ADDED  = 2'd0,
    RK_FULL   = 2'd1,
    RK_DONE   = 2'd2,
    RK_NOTICE = 2'd3
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT_RD,
    S_TGT_CHK,
    S_SLOT_RD,
    S_SLOT_CMP,
    S_NOTE2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic [3:0]         box_type;
    logic               has_callback;
    logic [3:0]         target_slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] receiver_slot;
    logic [3:0] other_slot;
    logic [3:0] receiver_kind;
    logic [3:0] other_kind;
    logic       last;
  } result_t;

  // one table entry as held in the RAM
  typedef struct packed {
    logic        notify;
    logic [3:0]  kind;
    logic [14:0] h;
    logic [14:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

endpackage

>>> sv/aabb_collider_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_collider_table_top
// Rectangle table with add / mark / purge / clear and per-slot overlap scans.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer
//  ---------+----------------------------------+------------------------------
//  command  | start, busy, cmd                 | start && !busy at clk edge
//  result   | result_valid, result             | one cycle per strobe
//  config   | cfg_we, cfg_index, cfg_data      | cfg_we at clk edge
//
// Non-scan ops and scans of a free slot: one result the cycle after accept,
// busy stays low. A used-slot scan fetches the target entry (S_TGT_RD, S_TGT_CHK),
// then (initiators only) skips each free slot and the target, reads each other
// used slot and runs the overlap unit on it (S_SLOT_RD, S_SLOT_CMP), gives any second
// notice in S_NOTE2, then ends with the done marker. Sync reset empties the table at
// once. Results cannot be stalled.
// ----------------------------------------------------------------------------
module aabb_collider_table_top #(
  parameter int SLOTS = act_pkg::SLOTS_DEF,
  parameter int KINDS = act_pkg::KINDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  act_pkg::cmd_t                 cmd,
  output logic                          result_valid,
  output act_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [act_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [act_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam logic [5:0] SLOTS_L = 6'(SLOTS);
  localparam logic [4:0] KINDS_L = 5'(KINDS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam int MASK_W = act_pkg::MASK_REGS * act_pkg::CFG_DATA_W;
  localparam logic [act_pkg::NOTE_CNT_W-1:0] NOTE_LIMIT =
    act_pkg::MAX_NOTES[act_pkg::NOTE_CNT_W-1:0];

  act_pkg::state_t state, state_next;

  logic [MASK_W-1:0]             pair_mask;
  logic [act_pkg::INIT_W-1:0]    initiator;
  logic [SLOTS-1:0]              occupied, occupied_next;
  logic [SLOTS-1:0]              mark, mark_next;
  logic [SW-1:0]                 j, j_next;
  logic [act_pkg::NOTE_CNT_W-1:0] n, n_next;
  logic [3:0]                    tgt;
  act_pkg::entry_t               a_ent;
  logic [3:0]                    b_kind;

  act_pkg::result_t              res_next;
  logic                          res_valid_next;

  logic                          ram_we;
  logic [SW-1:0]                 ram_waddr, ram_raddr;
  act_pkg::entry_t               ram_wdata, ram_rdata;

  logic                          accept;
  logic                          tgt_ok;
  logic [SW-1:0]                 tgt_idx, free_idx;
  logic                          free_any;
  logic                          hit, note1, note2;
  logic signed [16:0]            ax, ay, bx, by, axw, ayh, bxw, byh;

  function automatic logic pair_ok(input logic [MASK_W-1:0] pm, input logic [4:0] kl,
                                   input logic [3:0] t, input logic [3:0] o);
    pair_ok = ({1'b0, t} < kl) && ({1'b0, o} < kl) && pm[{t, o}];
  endfunction

  act_ram #(
    .WIDTH ($bits(act_pkg::entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy    = (state != act_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign tgt_idx = SW'(cmd.target_slot);
  assign tgt_ok  = ({2'b00, cmd.target_slot} < SLOTS_L) && occupied[tgt_idx];

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  // overlap unit: target entry against the entry just read
  always_comb begin
    ax  = 17'($signed(a_ent.x));
    ay  = 17'($signed(a_ent.y));
    bx  = 17'($signed(ram_rdata.x));
    by  = 17'($signed(ram_rdata.y));
    axw = ax + $signed({2'b00, a_ent.w});
    ayh = ay + $signed({2'b00, a_ent.h});
    bxw = bx + $signed({2'b00, ram_rdata.w});
    byh = by + $signed({2'b00, ram_rdata.h});
    hit = (ax < bxw) && (axw > bx) && (ay < byh) && (ayh > by);
    note1 = hit && a_ent.notify && pair_ok(pair_mask, KINDS_L, a_ent.kind, ram_rdata.kind);
    note2 = hit && ram_rdata.notify
            && pair_ok(pair_mask, KINDS_L, ram_rdata.kind, a_ent.kind);
  end

  always_comb begin
    state_next     = state;
    occupied_next  = occupied;
    mark_next      = mark;
    j_next         = j;
    n_next         = n;
    res_valid_next = 1'b0;
    res_next       = '0;
    ram_we         = 1'b0;
    ram_waddr      = free_idx;
    ram_raddr      = j;
    ram_wdata.notify = cmd.has_callback;
    ram_wdata.kind   = cmd.box_type;
    ram_wdata.h      = cmd.rect_h;
    ram_wdata.w      = cmd.rect_w;
    ram_wdata.y      = cmd.rect_y;
    ram_wdata.x      = cmd.rect_x;

    case (state)
      act_pkg::S_IDLE: begin
        if (accept) begin
          res_valid_next = 1'b1;
          res_next.last  = 1'b1;
          res_next.kind  = act_pkg::RK_DONE;
          case (cmd.op)
            act_pkg::OP_ADD: begin
              if (free_any) begin
                ram_we                  = 1'b1;
                occupied_next[free_idx] = 1'b1;
                mark_next[free_idx]     = 1'b0;
                res_next.kind           = act_pkg::RK_ADDED;
                res_next.receiver_slot  = 4'(free_idx);
                res_next.receiver_kind  = cmd.box_type;
              end else begin
                res_next.kind = act_pkg::RK_FULL;
              end
            end
            act_pkg::OP_MARK: begin
              if (tgt_ok) begin
                mark_next[tgt_idx] = 1'b1;
              end
              res_next.receiver_slot = cmd.target_slot;
            end
            act_pkg::OP_PURGE: begin
              occupied_next = occupied & ~mark;
              mark_next     = '0;
            end
            act_pkg::OP_CLEAR: begin
              occupied_next = '0;
              mark_next     = '0;
            end
            act_pkg::OP_SCAN: begin
              res_next.receiver_slot = cmd.target_slot;
              if (tgt_ok) begin
                res_valid_next = 1'b0;
                state_next     = act_pkg::S_TGT_RD;
              end
            end
            default: begin
              // unknown op: done marker on the target slot
              res_next.receiver_slot = cmd.target_slot;
            end
          endcase
        end
      end
      act_pkg::S_TGT_RD: begin
        ram_raddr  = SW'(tgt);
        state_next = act_pkg::S_TGT_CHK;
      end
      act_pkg::S_TGT_CHK: begin
        // a_ent loads from ram_rdata at this edge
        j_next = '0;
        n_next = '0;
        if (({1'b0, ram_rdata.kind} < KINDS_L) && initiator[ram_rdata.kind]) begin
          state_next = act_pkg::S_SLOT_RD;
        end else begin
          state_next = act_pkg::S_DONE;
        end
      end
      act_pkg::S_SLOT_RD: begin
        ram_raddr = j;
        if ((j == SW'(tgt)) || !occupied[j]) begin
          if (j == LAST_SLOT) begin
            state_next = act_pkg::S_DONE;
          end else begin
            j_next = j + 1'b1;
          end
        end else begin
          state_next = act_pkg::S_SLOT_CMP;
        end
      end
      act_pkg::S_SLOT_CMP: begin
        if (note1 && (n < NOTE_LIMIT)) begin
          res_valid_next         = 1'b1;
          res_next.kind          = act_pkg::RK_NOTICE;
          res_next.receiver_slot = tgt;
          res_next.other_slot    = 4'(j);
          res_next.receiver_kind = a_ent.kind;
          res_next.other_kind    = ram_rdata.kind;
          n_next                 = n + 1'b1;
        end
        if (note2) begin
          state_next = act_pkg::S_NOTE2;
        end else if (j == LAST_SLOT) begin
          state_next = act_pkg::S_DONE;
        end else begin
          j_next     = j + 1'b1;
          state_next = act_pkg::S_SLOT_RD;
        end
      end
      act_pkg::S_NOTE2: begin
        if (n < NOTE_LIMIT) begin
          res_valid_next         = 1'b1;
          res_next.kind          = act_pkg::RK_NOTICE;
          res_next.receiver_slot = 4'(j);
          res_next.other_slot    = tgt;
          res_next.receiver_kind = b_kind;
          res_next.other_kind    = a_ent.kind;
          n_next                 = n + 1'b1;
        end
        if (j == LAST_SLOT) begin
          state_next = act_pkg::S_DONE;
        end else begin
          j_next     = j + 1'b1;
          state_next = act_pkg::S_SLOT_RD;
        end
      end
      act_pkg::S_DONE: begin
        res_valid_next         = 1'b1;
        res_next.kind          = act_pkg::RK_DONE;
        res_next.receiver_slot = tgt;
        res_next.last          = 1'b1;
        state_next             = act_pkg::S_IDLE;
      end
      default: begin
        state_next = act_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= act_pkg::S_IDLE;
      occupied     <= '0;
      mark         <= '0;
      result_valid <= 1'b0;
      j            <= '0;
      n            <= '0;
    end else begin
      state        <= state_next;
      occupied     <= occupied_next;
      mark         <= mark_next;
      result_valid <= res_valid_next;
      j            <= j_next;
      n            <= n_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= res_next;
    if (accept) begin
      tgt <= cmd.target_slot;
    end
    if (state == act_pkg::S_TGT_CHK) begin
      a_ent <= ram_rdata;
    end
    if (state == act_pkg::S_SLOT_CMP) begin
      b_kind <= ram_rdata.kind;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_mask <= '0;
      initiator <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        act_pkg::CFG_MASK_0_3:
          pair_mask[0*act_pkg::CFG_DATA_W +: act_pkg::CFG_DATA_W] <= cfg_data;
        act_pkg::CFG_MASK_4_7:
          pair_mask[1*act_pkg::CFG_DATA_W +: act_pkg::CFG_DATA_W] <= cfg_data;
        act_pkg::CFG_MASK_8_11:
          pair_mask[2*act_pkg::CFG_DATA_W +: act_pkg::CFG_DATA_W] <= cfg_data;
        act_pkg::CFG_MASK_12_15:
          pair_mask[3*act_pkg::CFG_DATA_W +: act_pkg::CFG_DATA_W] <= cfg_data;
        act_pkg::CFG_INITIATOR:  initiator <= cfg_data[act_pkg::INIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/act_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
